// ----- src/mfhd_pkg.sv -----
// Shared types and constants for the MQTT fixed-header deframer.
`timescale 1ns / 1ps

package mfhd_pkg;

    localparam int MAX_LENGTH_BYTES = 4;
    localparam int LEN_W            = 28;

    localparam logic [2:0] LEN_LIMIT = 3'(MAX_LENGTH_BYTES);

    localparam logic       KIND_HEADER = 1'b0;
    localparam logic       KIND_DATA   = 1'b1;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef struct packed {
        logic             item_kind;
        logic [3:0]       ctrl_type;
        logic [3:0]       header_flags;
        logic [LEN_W-1:0] rem_len;
        logic [7:0]       data_byte;
        logic             last;
    } t_result;

endpackage

// ----- src/mfhd_in_stage.sv -----
// Input register stage: holds one received byte until the decoder takes it.
`timescale 1ns / 1ps

module mfhd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_rx_byte
);
    import mfhd_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready   = !r_valid || i_take;
    assign o_valid   = r_valid;
    assign o_rx_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_rx_byte;
        end
    end

endmodule

// ----- src/mfhd_out_stage.sv -----
// Output register stage: holds one result until the receiver takes it.
`timescale 1ns / 1ps

module mfhd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mfhd_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output mfhd_pkg::t_result o_result
);
    import mfhd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- src/mfhd_decoder.sv -----
// Per-byte decoder: packet phase, length accumulation and result build.
`timescale 1ns / 1ps

module mfhd_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_out_free,
    output logic              o_take,
    output logic              o_emit,
    output mfhd_pkg::t_result o_result
);
    import mfhd_pkg::*;

    t_phase           r_phase,        n_phase;
    logic [1:0]       r_idx,          n_idx;
    logic [LEN_W-1:0] r_acc,          n_acc;
    logic [LEN_W-1:0] r_payload_left, n_payload_left;
    logic [3:0]       r_type,         n_type;
    logic [3:0]       r_flags,        n_flags;

    logic [LEN_W-1:0] w_shifted;
    logic [LEN_W-1:0] w_acc;
    logic             w_len_done;
    logic             w_fin;
    logic             w_emits;

    always_comb begin
        case (r_idx)
            2'd0:    w_shifted = {21'd0, i_rx_byte[6:0]};
            2'd1:    w_shifted = {14'd0, i_rx_byte[6:0], 7'd0};
            2'd2:    w_shifted = {7'd0, i_rx_byte[6:0], 14'd0};
            default: w_shifted = {i_rx_byte[6:0], 21'd0};
        endcase
    end

    assign w_acc      = r_acc | w_shifted;
    assign w_len_done = !i_rx_byte[7] || (({1'b0, r_idx} + 3'd1) >= LEN_LIMIT);
    assign w_fin      = (r_payload_left <= LEN_W'(1));

    always_comb begin
        n_phase        = r_phase;
        n_idx          = r_idx;
        n_acc          = r_acc;
        n_payload_left = r_payload_left;
        n_type         = r_type;
        n_flags        = r_flags;
        w_emits        = 1'b0;
        o_result       = '{item_kind: KIND_HEADER, ctrl_type: r_type,
                           header_flags: r_flags, rem_len: w_acc,
                           data_byte: 8'd0, last: 1'b0};
        case (r_phase)
            PH_LEN: begin
                n_acc = w_acc;
                if (w_len_done) begin
                    w_emits         = 1'b1;
                    o_result.last   = (w_acc == '0);
                    n_payload_left  = w_acc;
                    n_idx           = 2'd0;
                    n_phase         = (w_acc == '0) ? PH_WAIT : PH_DATA;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            PH_DATA: begin
                w_emits            = 1'b1;
                o_result.item_kind = KIND_DATA;
                o_result.rem_len   = r_acc;
                o_result.data_byte = i_rx_byte;
                o_result.last      = w_fin;
                n_payload_left     = w_fin ? '0 : r_payload_left - LEN_W'(1);
                if (w_fin) begin
                    n_phase = PH_WAIT;
                end
            end
            default: begin
                n_type         = i_rx_byte[7:4];
                n_flags        = i_rx_byte[3:0];
                n_acc          = '0;
                n_idx          = 2'd0;
                n_payload_left = '0;
                n_phase        = PH_LEN;
            end
        endcase
    end

    assign o_take = i_valid && (i_out_free || !w_emits);
    assign o_emit = o_take && w_emits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_WAIT;
            r_idx          <= 2'd0;
            r_payload_left <= '0;
        end else if (o_take) begin
            r_phase        <= n_phase;
            r_idx          <= n_idx;
            r_payload_left <= n_payload_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_type  <= 4'd0;
            r_flags <= 4'd0;
        end else if (o_take) begin
            r_acc   <= n_acc;
            r_type  <= n_type;
            r_flags <= n_flags;
        end
    end

    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_payload_left != '0)
        else $error("payload phase with no bytes left");

    a_idx_only_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_LEN |-> r_idx == 2'd0)
        else $error("length index set outside length phase");

    a_last_ends_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit && o_result.last |=> r_phase == PH_WAIT)
        else $error("last result did not return to waiting");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> i_out_free)
        else $error("result produced with output slot full");

endmodule

// ----- src/mqtt_fixed_header_deframer.sv -----
// Top level of the MQTT fixed-header deframer.
//
// Input channel: i_valid / o_ready with i_rx_byte, one byte of a back-to-back
// stream of MQTT control packets per transfer. Output channel: o_valid /
// i_ready with one result per transfer: a header item (type, flags,
// remaining length; last when the length is zero) once the length bytes are
// complete, then one data item per payload byte, the final one marked last.
// The first byte and non-final length bytes give no result.
//
// A byte that transfers is taken by the input register; the decoder between the
// two registers forms its result, if any, combinationally, and the result
// register takes that result once it is free. Throughput: one byte per cycle
// while the result register is free or the byte gives no result.
//
// Reset clears both stages and returns the decoder to waiting for the first
// byte of a packet. When the receiver stalls, the result register holds and
// the input register keeps one byte; bytes that give no result still drain.
`timescale 1ns / 1ps

module mqtt_fixed_header_deframer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_rx_byte,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_item_kind,
    output logic [3:0]                 o_ctrl_type,
    output logic [3:0]                 o_header_flags,
    output logic [mfhd_pkg::LEN_W-1:0] o_rem_len,
    output logic [7:0]                 o_data_byte,
    output logic                       o_last
);
    import mfhd_pkg::*;

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_take;
    logic       w_emit;
    logic       w_out_free;
    t_result    w_result;
    t_result    w_out_result;

    mfhd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_take    (w_take),
        .o_valid   (w_in_valid),
        .o_rx_byte (w_in_byte)
    );

    mfhd_decoder u_decoder (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_in_valid),
        .i_rx_byte  (w_in_byte),
        .i_out_free (w_out_free),
        .o_take     (w_take),
        .o_emit     (w_emit),
        .o_result   (w_result)
    );

    mfhd_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_emit),
        .i_result (w_result),
        .i_ready  (i_ready),
        .o_free   (w_out_free),
        .o_valid  (o_valid),
        .o_result (w_out_result)
    );

    assign o_item_kind    = w_out_result.item_kind;
    assign o_ctrl_type    = w_out_result.ctrl_type;
    assign o_header_flags = w_out_result.header_flags;
    assign o_rem_len      = w_out_result.rem_len;
    assign o_data_byte    = w_out_result.data_byte;
    assign o_last         = w_out_result.last;

endmodule
